@@ hdl/r2h_pkg.sv @@
// r2h_pkg: shared widths, constants and payload types of the rgb to hsl pipeline
`default_nettype none

package r2h_pkg;

  localparam int unsigned COMP_BITS     = 8;
  localparam int unsigned HUE_FRAC_BITS = 13;
  localparam int unsigned SAT_FRAC_BITS = 16;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned SAT_W   = 16;
  localparam int unsigned LIGHT_W = COMP_BITS + 1;

  localparam int unsigned SUM_W = COMP_BITS + 1;
  localparam int unsigned DIV_W = COMP_BITS + 2;
  localparam int unsigned N6_W  = COMP_BITS + 3;

  localparam int unsigned PIQ_W     = 34;
  localparam int unsigned PIQ_BITS  = 32;
  localparam logic [PIQ_W-1:0] PIQ  = 34'd13493037704;
  localparam int unsigned HUE_SHIFT = PIQ_BITS - HUE_FRAC_BITS;
  localparam int unsigned PROD_W    = N6_W + PIQ_W;

  localparam int unsigned Q_RAW      = (HUE_FRAC_BITS + 3 > SAT_FRAC_BITS + 1) ?
                                       (HUE_FRAC_BITS + 3) : (SAT_FRAC_BITS + 1);
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = (Q_RAW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned Q_W        = DIV_STAGES * DIV_STEPS;
  localparam int unsigned NUM_W      = DIV_W + Q_W;
  localparam int unsigned NUM_STAGES = DIV_STAGES + 3;

  localparam logic [COMP_BITS-1:0] FS        = {COMP_BITS{1'b1}};
  localparam logic [LIGHT_W-1:0]   LIGHT_MAX = {FS, 1'b0};

  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [LIGHT_W-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [Q_W-1:0]   acc;
    logic [DIV_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] light;
    logic               grey;
    div_t               sat;
    div_t               hue;
  } pipe_t;

endpackage

`default_nettype wire

@@ hdl/r2h_front.sv @@
// r2h_front: max/min and sector stage, then hue scaling multiply and divider set-up
`default_nettype none

module r2h_front import r2h_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire pix_t       pix_i,
  input  wire logic [1:0] load_i,
  output logic      [1:0] valid_o,
  output pipe_t           data_o
);

  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic                 grey;
    logic [COMP_BITS-1:0] d;
    logic [SUM_W-1:0]     den;
    logic [N6_W-1:0]      n6;
  } front_t;

  logic [1:0] valid_q;
  front_t     s1_d, s1_q;
  pipe_t      s2_d, s2_q;

  logic [COMP_BITS-1:0] mx, mn;
  logic [N6_W-1:0]      d1, d2, d4, d6;
  logic [PROD_W-1:0]    prod;
  logic [NUM_W-1:0]     num_s, num_h;

  // sector analysis
  always_comb begin
    mx = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    mn = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;

    s1_d.sum  = SUM_W'(mx) + SUM_W'(mn);
    s1_d.grey = (mx == mn);
    s1_d.d    = mx - mn;
    if (s1_d.sum > SUM_W'(FS)) begin
      s1_d.den = SUM_W'({FS, 1'b0}) - s1_d.sum;
    end else begin
      s1_d.den = s1_d.sum;
    end

    d1 = N6_W'(s1_d.d);
    d2 = d1 << 1;
    d4 = d1 << 2;
    d6 = d4 + d2;
    if (mx == pix_i.red) begin
      if (pix_i.green >= pix_i.blue) begin
        s1_d.n6 = N6_W'(pix_i.green - pix_i.blue);
      end else begin
        s1_d.n6 = d6 - N6_W'(pix_i.blue - pix_i.green);
      end
    end else if (mx == pix_i.green) begin
      s1_d.n6 = d2 + N6_W'(pix_i.blue) - N6_W'(pix_i.red);
    end else begin
      s1_d.n6 = d4 + N6_W'(pix_i.red) - N6_W'(pix_i.green);
    end
  end

  // hue numerator scaling and divider initial state
  always_comb begin
    prod  = PROD_W'(s1_q.n6) * PROD_W'(PIQ);
    num_h = NUM_W'(prod >> HUE_SHIFT);
    num_s = NUM_W'(s1_q.d) << SAT_FRAC_BITS;

    s2_d.light   = LIGHT_W'(s1_q.sum);
    s2_d.grey    = s1_q.grey;
    s2_d.sat.rem = num_s[NUM_W-1:Q_W];
    s2_d.sat.acc = num_s[Q_W-1:0];
    s2_d.sat.den = DIV_W'(s1_q.den);
    s2_d.hue.rem = num_h[NUM_W-1:Q_W];
    s2_d.hue.acc = num_h[Q_W-1:0];
    s2_d.hue.den = DIV_W'(s1_q.d) + (DIV_W'(s1_q.d) << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load_i[0]) valid_q[0] <= valid_i;
      if (load_i[1]) valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) s1_q <= s1_d;
    if (load_i[1]) s2_q <= s2_d;
  end

  assign valid_o = valid_q;
  assign data_o  = s2_q;

endmodule

`default_nettype wire

@@ hdl/r2h_div_stage.sv @@
// r2h_div_stage: one register stage of the two restoring dividers
`default_nettype none

module r2h_div_stage import r2h_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire pipe_t data_i,
  input  wire logic  load_i,
  output logic       valid_o,
  output pipe_t      data_o
);

  function automatic div_t div_run(div_t x);
    div_t         y;
    logic [DIV_W:0] t;
    logic         ge;
    y = x;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {y.rem, y.acc[Q_W-1]};
      ge    = (t >= {1'b0, y.den});
      y.acc = {y.acc[Q_W-2:0], ge};
      if (ge) begin
        y.rem = DIV_W'(t - {1'b0, y.den});
      end else begin
        y.rem = DIV_W'(t);
      end
    end
    return y;
  endfunction

  logic  valid_q;
  pipe_t data_d, data_q;

  always_comb begin
    data_d     = data_i;
    data_d.sat = div_run(data_i.sat);
    data_d.hue = div_run(data_i.hue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/rgb_to_hsl_unit.sv @@
// rgb_to_hsl_unit: pipelined rgb to hue, saturation and lightness converter
// pipeline: sector and set-up stages in r2h_front, the divider stages, then the output register
// throughput: one pixel per clock while the output is not stalled; each stage refills as soon as it is emptied
// the two dividers retire DIV_STEPS quotient bits per stage over DIV_STAGES stages
// reset clears every stage valid bit; payload registers are not reset
`default_nettype none

module rgb_to_hsl_unit import r2h_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire pix_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output hsl_t      out_data_o
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   adv;
  pipe_t                 st_data [DIV_STAGES+1];

  logic out_valid_q;
  hsl_t out_d, out_q;

  assign adv[NUM_STAGES] = ~out_stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
    assign adv[k] = ~vld[k] | adv[k+1];
  end

  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .pix_i   (in_data_i),
    .load_i  (adv[1:0]),
    .valid_o (vld[1:0]),
    .data_o  (st_data[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    r2h_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k+1]),
      .data_i  (st_data[k]),
      .load_i  (adv[k+2]),
      .valid_o (vld[k+2]),
      .data_o  (st_data[k+1])
    );
  end

  // saturation clamp and grey pixels
  always_comb begin
    out_d.lightness = st_data[DIV_STAGES].light;
    out_d.hue       = st_data[DIV_STAGES].hue.acc[HUE_W-1:0];
    if (|st_data[DIV_STAGES].sat.acc[Q_W-1:SAT_W]) begin
      out_d.saturation = '1;
    end else begin
      out_d.saturation = st_data[DIV_STAGES].sat.acc[SAT_W-1:0];
    end
    if (st_data[DIV_STAGES].grey) begin
      out_d.hue        = '0;
      out_d.saturation = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv[NUM_STAGES-1]) begin
      out_valid_q <= vld[NUM_STAGES-2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NUM_STAGES-1]) out_q <= out_d;
  end

  assign vld[NUM_STAGES-1] = out_valid_q;
  assign in_stall_o        = ~adv[0];
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

@@ hdl/r2h_checker.sv @@
// r2h_checker: port-level assertions for rgb_to_hsl_unit and its bind
`default_nettype none

module r2h_checker import r2h_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire pix_t in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire hsl_t out_data_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ (|in_data_i);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input back-pressure only when the output side is full and stalled
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_light_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.lightness <= LIGHT_MAX)
    else $error("lightness out of range");

  // zero saturation means a grey pixel, whose hue is zero
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.saturation == '0) |-> out_data_o.hue == '0)
    else $error("grey pixel with non-zero hue");

endmodule

bind rgb_to_hsl_unit r2h_checker u_r2h_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ sim/tb.sv @@
// tb: self-checking bench for rgb_to_hsl_unit, directed table then random pixels with stalls
`default_nettype none

module tb import r2h_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PI_Q32 = 64'd13493037704;
  localparam int unsigned     FULL   = (1 << COMP_BITS) - 1;
  localparam int              N_RAND = 1700;

  typedef struct {
    pix_t pix;
    bit   fixed;
    hsl_t want;
  } row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  pix_t in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  hsl_t out_data_o;

  hsl_t hsl_due[$];
  row_t rows[$];
  int   mismatch_cnt = 0;

  always #6 clk_i = ~clk_i;

  rgb_to_hsl_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  function automatic hsl_t hsl_of(pix_t p);
    int r, g, b, mx, mn, d, sum, den, n6;
    longint unsigned q;
    hsl_t h;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    h = '0;
    h.lightness = LIGHT_W'(sum);
    if (mx != mn) begin
      d = mx - mn;
      den = (sum > FULL) ? (2 * FULL - sum) : sum;
      q = (longint'(d) << SAT_FRAC_BITS) / longint'(den);
      if (q > 65535) q = 65535;
      h.saturation = SAT_W'(q);
      if (mx == r) n6 = (g - b) + ((g < b) ? 6 * d : 0);
      else if (mx == g) n6 = (b - r) + 2 * d;
      else n6 = (r - g) + 4 * d;
      q = (longint'(n6) * PI_Q32) / longint'(3 * d);
      h.hue = HUE_W'(q >> (32 - HUE_FRAC_BITS));
    end
    return h;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned near_end();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return FULL - 1;
      3: return FULL;
      default: return $urandom_range(0, FULL);
    endcase
  endfunction

  function automatic pix_t rand_pix();
    int unsigned k, a, b, c;
    pix_t p;
    k = $urandom_range(0, 99);
    a = $urandom_range(0, FULL);
    b = $urandom_range(0, FULL);
    c = $urandom_range(0, FULL);
    if (k < 40) begin
    end else if (k < 52) begin
      b = a;
      c = a;
    end else if (k < 70) begin
      case ($urandom_range(0, 2))
        0: b = a;
        1: c = a;
        default: c = b;
      endcase
    end else if (k < 85) begin
      a = near_end();
      b = near_end();
      c = near_end();
    end else begin
      b = (a + $urandom_range(0, 6) + FULL - 2) % (FULL + 1);
      c = (a + $urandom_range(0, 6) + FULL - 2) % (FULL + 1);
    end
    p.red   = COMP_BITS'(a);
    p.green = COMP_BITS'(b);
    p.blue  = COMP_BITS'(c);
    return p;
  endfunction

  function automatic row_t mk(int r, int g, int b, bit fixed, int hu, int sa, int li);
    row_t w;
    w.pix.red          = COMP_BITS'(r);
    w.pix.green        = COMP_BITS'(g);
    w.pix.blue         = COMP_BITS'(b);
    w.fixed            = fixed;
    w.want.hue         = HUE_W'(hu);
    w.want.saturation  = SAT_W'(sa);
    w.want.lightness   = LIGHT_W'(li);
    return w;
  endfunction

  task automatic send(pix_t p, hsl_t want, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hsl_due.push_back(want);
  endtask

  always @(posedge clk_i) begin : check_out
    hsl_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hsl_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected transfer: hue %0d sat %0d light %0d", out_data_o.hue,
                   out_data_o.saturation, out_data_o.lightness);
      end else begin
        want = hsl_due.pop_front();
        if (out_data_o.hue !== want.hue || out_data_o.saturation !== want.saturation ||
            out_data_o.lightness !== want.lightness) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected hue %0d sat %0d light %0d, got hue %0d sat %0d light %0d",
                     want.hue, want.saturation, want.lightness, out_data_o.hue,
                     out_data_o.saturation, out_data_o.lightness);
        end
      end
    end
  end

  initial begin : sink
    int n;
    forever begin
      if ($urandom_range(0, 7) == 0) n = $urandom_range(100, 300);
      else n = $urandom_range(1, 12);
      out_stall_i <= 1'b0;
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n == 0) n = 1;
      out_stall_i <= 1'b1;
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : source
    int burst_left;
    int gap;
    pix_t p;
    burst_left = 0;
    //       red  green blue  fixed  hue  sat    light
    rows.push_back(mk(  0,   0,   0, 1,   0,     0,   0));
    rows.push_back(mk(255, 255, 255, 1,   0,     0, 510));
    rows.push_back(mk(128, 128, 128, 1,   0,     0, 256));
    rows.push_back(mk(255,   0,   0, 1,   0, 65535, 255));
    rows.push_back(mk(  1,   0,   0, 1,   0, 65535,   1));
    rows.push_back(mk(255, 254, 254, 1,   0, 65535, 509));
    rows.push_back(mk(  0, 255,   0, 0,   0,     0,   0));
    rows.push_back(mk(  0,   0, 255, 0,   0,     0,   0));
    rows.push_back(mk(255, 255,   0, 0,   0,     0,   0));
    rows.push_back(mk(  0, 255, 255, 0,   0,     0,   0));
    rows.push_back(mk(255,   0, 255, 0,   0,     0,   0));
    rows.push_back(mk(255,   0,   1, 0,   0,     0,   0));
    rows.push_back(mk(  1,   0, 255, 0,   0,     0,   0));
    rows.push_back(mk(  0,   1,   1, 0,   0,     0,   0));
    rows.push_back(mk(254, 255, 255, 0,   0,     0,   0));
    rows.push_back(mk(  1,   1,   0, 0,   0,     0,   0));
    rows.push_back(mk(128,   0,   0, 0,   0,     0,   0));
    rows.push_back(mk(255, 128,   0, 0,   0,     0,   0));
    rows.push_back(mk( 12, 200,  77, 0,   0,     0,   0));
    rows.push_back(mk(200,  12,  77, 0,   0,     0,   0));
    rows.push_back(mk(170,  85, 255, 0,   0,     0,   0));
    rows.push_back(mk(127, 128, 129, 0,   0,     0,   0));
    rows.push_back(mk( 85, 170, 170, 0,   0,     0,   0));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i])
      send(rows[i].pix, rows[i].fixed ? rows[i].want : hsl_of(rows[i].pix), pick_gap());
    for (int i = 0; i < N_RAND; i++) begin
      if (burst_left == 0 && $urandom_range(0, 15) == 0) burst_left = $urandom_range(40, 120);
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      p = rand_pix();
      send(p, hsl_of(p), gap);
    end
    in_valid_i <= 1'b0;
    while (hsl_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0 && hsl_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(15_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/r2h_pkg.sv
hdl/r2h_front.sv
hdl/r2h_div_stage.sv
hdl/rgb_to_hsl_unit.sv
hdl/r2h_checker.sv
sim/tb.sv
